### rtl/tcsr_pkg.sv
`timescale 1ns / 1ps
package tcsr_pkg;

  typedef enum logic [1:0] {
    PH_IDLE   = 2'd0,
    PH_FIRST  = 2'd1,
    PH_SECOND = 2'd2
  } walk_e;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_LOAD,
    ST_DIV_LONG,
    ST_UP_START,
    ST_DIV_UP,
    ST_MUL_U,
    ST_ADD_U,
    ST_MUL_L,
    ST_ADD_L,
    ST_SPAN,
    ST_OUT
  } state_e;

  localparam logic KIND_LOAD = 1'b0;
  localparam logic KIND_STEP = 1'b1;

  localparam int unsigned SlopeW = 32;
  localparam int unsigned ColW   = 13;

endpackage

### rtl/tcsr_div.sv
`timescale 1ns / 1ps
module tcsr_div (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                start_i,
  input  logic signed [15:0]  x0_i,
  input  logic signed [15:0]  y0_i,
  input  logic signed [15:0]  x1_i,
  input  logic signed [15:0]  y1_i,
  output logic                done_o,
  output logic signed [31:0]  slope_o
);
  import tcsr_pkg::*;

  logic        busy_q, busy_d;
  logic        done_q, done_d;
  logic [4:0]  cnt_q, cnt_d;
  logic [16:0] rem_q, rem_d;
  logic [31:0] num_q, num_d;
  logic [16:0] dx_q, dx_d;
  logic        neg_q, neg_d;
  logic        zero_q, zero_d;

  logic signed [16:0] dx_in, dy_in, mag;
  logic [16:0] rem_sh;
  logic        fits;

  // dx is never negative: vertices are sorted by x
  always_comb begin
    dx_in  = 17'(x1_i) - 17'(x0_i);
    dy_in  = 17'(y1_i) - 17'(y0_i);
    mag    = dy_in[16] ? -dy_in : dy_in;
    rem_sh = {rem_q[15:0], num_q[31]};
    fits   = rem_sh >= dx_q;
  end

  always_comb begin
    busy_d = busy_q;
    done_d = 1'b0;
    cnt_d  = cnt_q;
    rem_d  = rem_q;
    num_d  = num_q;
    dx_d   = dx_q;
    neg_d  = neg_q;
    zero_d = zero_q;
    if (start_i) begin
      busy_d = 1'b1;
      cnt_d  = '0;
      rem_d  = '0;
      num_d  = {mag[15:0], 16'h0000};
      dx_d   = dx_in;
      neg_d  = dy_in[16];
      zero_d = (dx_in == '0);
    end else if (busy_q) begin
      rem_d = fits ? (rem_sh - dx_q) : rem_sh;
      num_d = {num_q[30:0], fits};
      cnt_d = cnt_q + 5'd1;
      if (cnt_q == 5'd31) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q  <= rem_d;
    num_q  <= num_d;
    dx_q   <= dx_d;
    neg_q  <= neg_d;
    zero_q <= zero_d;
  end

  // sign and saturate to Q16.16; a zero dx gives a zero slope
  always_comb begin
    if (zero_q) begin
      slope_o = '0;
    end else if (!neg_q) begin
      slope_o = num_q[31] ? 32'sh7FFF_FFFF : signed'(num_q);
    end else begin
      slope_o = (num_q > 32'h8000_0000) ? 32'sh8000_0000 : signed'(-num_q);
    end
  end

  assign done_o = done_q;

endmodule

### rtl/triangle_column_span_rasterizer_core.sv
`timescale 1ns / 1ps
// Column-span triangle rasterizer.
// Input channel (in_valid_i/in_ready_o): kind_i = 0 loads three Q12.4
// vertices and a fill color, kind_i = 1 requests the next column span.
// Output channel (out_valid_o/out_ready_i): one span per step request,
// none per load. Spans of a triangle come left to right; the center column
// appears twice, once per half. span_last_o marks the final span; a step
// request with no triangle in progress returns an empty span with
// span_last_o set.
// Timing: a load runs two slope divisions in one shared restoring
// divider, one bit per cycle. A step sends both span rows through one
// shared 14x32 multiplier and one adder. The step that crosses into the
// second half runs the divider once more after its span is registered.
// One request is in flight at a time; in_ready_o is low while it is worked.
// A finished span sits in the output register; if the receiver stalls, a
// following step waits at the end of its work until the register frees.
// Reset clears the control and triangle registers, not the datapath ones;
// the block comes up idle with no triangle loaded.
module triangle_column_span_rasterizer_core #(
  parameter int SCREEN_SIZE = 800
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  logic               kind_i,
  input  logic signed [15:0] vertex_a_x_i,
  input  logic signed [15:0] vertex_a_y_i,
  input  logic signed [15:0] vertex_b_x_i,
  input  logic signed [15:0] vertex_b_y_i,
  input  logic signed [15:0] vertex_c_x_i,
  input  logic signed [15:0] vertex_c_y_i,
  input  logic [7:0]         fill_color_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output logic [9:0]         column_o,
  output logic [9:0]         row_top_o,
  output logic [9:0]         row_bottom_o,
  output logic [7:0]         span_color_o,
  output logic               span_empty_o,
  output logic               span_last_o
);
  import tcsr_pkg::*;

  localparam logic signed [ColW-1:0] ScrMax = ColW'(SCREEN_SIZE - 1);
  localparam logic signed [31:0]     ScrLim = 32'(SCREEN_SIZE);

  state_e state_q, state_d;
  walk_e  phase_q, phase_d;

  logic signed [15:0]       vert_q [6];
  logic signed [15:0]       vert_d [6];
  logic signed [ColW-1:0]   ec_q [3];
  logic signed [ColW-1:0]   ec_d [3];
  logic signed [ColW-1:0]   cur_q, cur_d;
  logic signed [SlopeW-1:0] upper_q, upper_d, long_q, long_d;
  logic [7:0]               color_q, color_d;
  logic                     upsel_q, upsel_d;
  logic                     need_div_q, need_div_d;
  logic signed [47:0]       prod_q, prod_d;
  logic signed [31:0]       row_u_q, row_u_d, row_l_q, row_l_d;

  logic [9:0] res_col_q, res_col_d, res_top_q, res_top_d, res_bot_q, res_bot_d;
  logic       res_empty_q, res_empty_d, res_last_q, res_last_d;

  logic       out_valid_q, out_valid_d;
  logic [9:0] out_col_q, out_top_q, out_bot_q;
  logic [7:0] out_color_q;
  logic       out_empty_q, out_last_q;
  logic       out_load;

  logic in_acc;
  logic div_start, div_done;
  logic signed [15:0] dx0, dy0, dx1, dy1;
  logic signed [31:0] div_slope;

  // sort network and rounding
  logic signed [15:0] s [6];
  logic signed [15:0] t0, t1;
  logic signed [ColW-1:0] rc [3];

  function automatic logic signed [ColW-1:0] round_q4(input logic signed [15:0] v);
    logic [16:0] m;
    m = v[15] ? 17'(-17'(v)) : 17'(v);
    m = (m + 17'd8) >> 4;
    return v[15] ? -ColW'(m) : ColW'(m);
  endfunction

  function automatic logic signed [ColW-1:0] max0(input logic signed [ColW-1:0] v);
    return v[ColW-1] ? '0 : v;
  endfunction

  function automatic logic signed [ColW-1:0] minscr(input logic signed [ColW-1:0] v);
    return (v > ScrMax) ? ScrMax : v;
  endfunction

  always_comb begin
    t0 = '0;
    t1 = '0;
    s[0] = vertex_a_x_i; s[1] = vertex_a_y_i;
    s[2] = vertex_b_x_i; s[3] = vertex_b_y_i;
    s[4] = vertex_c_x_i; s[5] = vertex_c_y_i;
    if (s[2] < s[0]) begin
      t0 = s[0]; t1 = s[1]; s[0] = s[2]; s[1] = s[3]; s[2] = t0; s[3] = t1;
    end
    if (s[4] < s[2]) begin
      t0 = s[2]; t1 = s[3]; s[2] = s[4]; s[3] = s[5]; s[4] = t0; s[5] = t1;
    end
    if (s[2] < s[0]) begin
      t0 = s[0]; t1 = s[1]; s[0] = s[2]; s[1] = s[3]; s[2] = t0; s[3] = t1;
    end
    rc[0] = round_q4(s[0]);
    rc[1] = round_q4(s[2]);
    rc[2] = round_q4(s[4]);
  end

  // divider operands: long edge on load, else the selected short edge
  always_comb begin
    div_start = (state_q == ST_LOAD) || (state_q == ST_UP_START);
    if (state_q == ST_LOAD) begin
      dx0 = vert_q[0]; dy0 = vert_q[1]; dx1 = vert_q[4]; dy1 = vert_q[5];
    end else if (upsel_q) begin
      dx0 = vert_q[2]; dy0 = vert_q[3]; dx1 = vert_q[4]; dy1 = vert_q[5];
    end else begin
      dx0 = vert_q[0]; dy0 = vert_q[1]; dx1 = vert_q[2]; dy1 = vert_q[3];
    end
  end

  tcsr_div u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (div_start),
    .x0_i    (dx0),
    .y0_i    (dy0),
    .x1_i    (dx1),
    .y1_i    (dy1),
    .done_o  (div_done),
    .slope_o (div_slope)
  );

  // shared multiply and round datapath
  logic signed [ColW-1:0]   mul_start;
  logic signed [SlopeW-1:0] mul_slope;
  logic signed [13:0]       mul_diff;
  logic signed [15:0]       add_y;
  logic signed [47:0]       acc, acc_mag;
  logic signed [31:0]       rounded;

  always_comb begin
    if (state_q == ST_MUL_U && phase_q == PH_SECOND) begin
      mul_start = ec_q[1];
    end else begin
      mul_start = ec_q[0];
    end
    mul_slope = (state_q == ST_MUL_U) ? upper_q : long_q;
    mul_diff  = 14'(cur_q) - 14'(mul_start);
    add_y     = (state_q == ST_ADD_U && phase_q == PH_SECOND) ? vert_q[3] : vert_q[1];
    acc       = (48'(add_y) <<< 12) + prod_q;
    acc_mag   = acc[47] ? -acc : acc;
    acc_mag   = (acc_mag + 48'sh8000) >>> 16;
    rounded   = acc[47] ? -32'(acc_mag) : 32'(acc_mag);
  end

  // span clip
  logic signed [31:0] lo, hi;
  logic               sp_empty;
  logic signed [13:0] col_nx;
  always_comb begin
    lo = (row_u_q > row_l_q) ? row_l_q : row_u_q;
    hi = (row_u_q > row_l_q) ? row_u_q : row_l_q;
    sp_empty = hi[31] || (lo >= ScrLim);
    if (sp_empty) begin
      lo = '0;
      hi = '0;
    end else begin
      if (lo[31]) lo = '0;
      if (hi > ScrLim - 32'sd1) hi = ScrLim - 32'sd1;
    end
    col_nx = 14'(cur_q) + 14'sd1;
  end

  assign in_ready_o = (state_q == ST_IDLE);
  assign in_acc     = in_valid_i && in_ready_o;
  assign out_load   = (state_q == ST_OUT) && (!out_valid_q || out_ready_i);

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (in_acc) begin
          if (kind_i == KIND_LOAD) state_d = ST_LOAD;
          else if (phase_q == PH_IDLE) state_d = ST_OUT;
          else state_d = ST_MUL_U;
        end
      end
      ST_LOAD:     state_d = ST_DIV_LONG;
      ST_DIV_LONG: begin
        if (div_done) begin
          if (max0(ec_q[0]) <= minscr(ec_q[1])) state_d = ST_UP_START;
          else if (max0(ec_q[1]) <= minscr(ec_q[2])) state_d = ST_UP_START;
          else state_d = ST_IDLE;
        end
      end
      ST_UP_START: state_d = ST_DIV_UP;
      ST_DIV_UP:   if (div_done) state_d = ST_IDLE;
      ST_MUL_U:    state_d = ST_ADD_U;
      ST_ADD_U:    state_d = ST_MUL_L;
      ST_MUL_L:    state_d = ST_ADD_L;
      ST_ADD_L:    state_d = ST_SPAN;
      ST_SPAN:     state_d = ST_OUT;
      ST_OUT: begin
        if (out_load) state_d = need_div_q ? ST_UP_START : ST_IDLE;
      end
      default:     state_d = ST_IDLE;
    endcase
  end

  // datapath and walk state updates
  always_comb begin
    phase_d     = phase_q;
    vert_d      = vert_q;
    ec_d        = ec_q;
    cur_d       = cur_q;
    upper_d     = upper_q;
    long_d      = long_q;
    color_d     = color_q;
    upsel_d     = upsel_q;
    need_div_d  = need_div_q;
    prod_d      = prod_q;
    row_u_d     = row_u_q;
    row_l_d     = row_l_q;
    res_col_d   = res_col_q;
    res_top_d   = res_top_q;
    res_bot_d   = res_bot_q;
    res_empty_d = res_empty_q;
    res_last_d  = res_last_q;
    out_valid_d = out_valid_q && !out_ready_i;
    case (state_q)
      ST_IDLE: begin
        if (in_acc) begin
          if (kind_i == KIND_LOAD) begin
            vert_d  = s;
            ec_d    = rc;
            color_d = fill_color_i;
          end else begin
            need_div_d  = 1'b0;
            res_col_d   = '0;
            res_top_d   = '0;
            res_bot_d   = '0;
            res_empty_d = 1'b1;
            res_last_d  = 1'b1;
          end
        end
      end
      ST_DIV_LONG: begin
        if (div_done) begin
          long_d = div_slope;
          if (max0(ec_q[0]) <= minscr(ec_q[1])) begin
            upsel_d = 1'b0;
            cur_d   = max0(ec_q[0]);
            phase_d = PH_FIRST;
          end else if (max0(ec_q[1]) <= minscr(ec_q[2])) begin
            upsel_d = 1'b1;
            cur_d   = max0(ec_q[1]);
            phase_d = PH_SECOND;
          end else begin
            phase_d = PH_IDLE;
          end
        end
      end
      ST_DIV_UP: begin
        if (div_done) upper_d = div_slope;
      end
      ST_MUL_U, ST_MUL_L: prod_d = 48'(mul_diff * mul_slope);
      ST_ADD_U: row_u_d = rounded;
      ST_ADD_L: row_l_d = rounded;
      ST_SPAN: begin
        need_div_d  = 1'b0;
        res_col_d   = cur_q[9:0];
        res_top_d   = lo[9:0];
        res_bot_d   = hi[9:0];
        res_empty_d = sp_empty;
        if (phase_q == PH_FIRST) begin
          if (col_nx <= 14'(minscr(ec_q[1]))) begin
            cur_d = col_nx[ColW-1:0];
          end else if (max0(ec_q[1]) <= minscr(ec_q[2])) begin
            upsel_d    = 1'b1;
            need_div_d = 1'b1;
            cur_d      = max0(ec_q[1]);
            phase_d    = PH_SECOND;
          end else begin
            phase_d = PH_IDLE;
          end
        end else begin
          if (col_nx <= 14'(minscr(ec_q[2]))) cur_d = col_nx[ColW-1:0];
          else phase_d = PH_IDLE;
        end
        res_last_d = 1'b0;
        if (phase_q == PH_FIRST && !(col_nx <= 14'(minscr(ec_q[1])))
            && !(max0(ec_q[1]) <= minscr(ec_q[2]))) res_last_d = 1'b1;
        if (phase_q == PH_SECOND && !(col_nx <= 14'(minscr(ec_q[2]))))
          res_last_d = 1'b1;
      end
      ST_OUT: begin
        if (out_load) out_valid_d = 1'b1;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      phase_q     <= PH_IDLE;
      out_valid_q <= 1'b0;
      need_div_q  <= 1'b0;
      upsel_q     <= 1'b0;
      cur_q       <= '0;
      upper_q     <= '0;
      long_q      <= '0;
      color_q     <= '0;
      for (int i = 0; i < 6; i++) vert_q[i] <= '0;
      for (int i = 0; i < 3; i++) ec_q[i] <= '0;
    end else begin
      state_q     <= state_d;
      phase_q     <= phase_d;
      out_valid_q <= out_valid_d;
      need_div_q  <= need_div_d;
      upsel_q     <= upsel_d;
      cur_q       <= cur_d;
      upper_q     <= upper_d;
      long_q      <= long_d;
      color_q     <= color_d;
      vert_q      <= vert_d;
      ec_q        <= ec_d;
    end
  end

  always_ff @(posedge clk_i) begin
    prod_q      <= prod_d;
    row_u_q     <= row_u_d;
    row_l_q     <= row_l_d;
    res_col_q   <= res_col_d;
    res_top_q   <= res_top_d;
    res_bot_q   <= res_bot_d;
    res_empty_q <= res_empty_d;
    res_last_q  <= res_last_d;
    if (out_load) begin
      out_col_q   <= res_col_q;
      out_top_q   <= res_top_q;
      out_bot_q   <= res_bot_q;
      out_color_q <= color_q;
      out_empty_q <= res_empty_q;
      out_last_q  <= res_last_q;
    end
  end

  assign out_valid_o  = out_valid_q;
  assign column_o     = out_col_q;
  assign row_top_o    = out_top_q;
  assign row_bottom_o = out_bot_q;
  assign span_color_o = out_color_q;
  assign span_empty_o = out_empty_q;
  assign span_last_o  = out_last_q;

  a_cur_on_screen: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (phase_q != PH_IDLE) |-> (!cur_q[ColW-1] && cur_q <= ScrMax))
    else $error("current column off screen while walking");

  a_empty_rows_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && span_empty_o) |-> (row_top_o == '0 && row_bottom_o == '0))
    else $error("empty span carries rows");

  a_rows_ordered: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !span_empty_o) |-> (row_top_o <= row_bottom_o))
    else $error("span rows out of order");

endmodule

### bench/tb_top.sv
`timescale 1ns / 1ps
module tb_top;
  import tcsr_pkg::*;

  localparam int Screen = 800;
  localparam int StallLimit = 20000;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic in_valid_i = 1'b0;
  logic in_ready_o;
  logic kind_i = KIND_STEP;
  logic signed [15:0] vertex_a_x_i = '0, vertex_a_y_i = '0;
  logic signed [15:0] vertex_b_x_i = '0, vertex_b_y_i = '0;
  logic signed [15:0] vertex_c_x_i = '0, vertex_c_y_i = '0;
  logic [7:0] fill_color_i = '0;
  logic out_valid_o;
  logic out_ready_i = 1'b0;
  logic [9:0] column_o, row_top_o, row_bottom_o;
  logic [7:0] span_color_o;
  logic span_empty_o, span_last_o;

  triangle_column_span_rasterizer_core #(.SCREEN_SIZE(Screen)) DUT (.*);

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  typedef struct packed {
    logic [9:0] column;
    logic [9:0] row_top;
    logic [9:0] row_bottom;
    logic [7:0] color;
    logic       empty;
    logic       last;
  } span_t;

  typedef struct {
    logic              kind;
    logic signed [15:0] v[6];
    logic [7:0]        color;
    logic              has_known;
    span_t             known;
  } request_t;

  // predictor state
  int signed tri_v[6];
  int signed tri_col[3];
  int signed slope_up, slope_long, walk_col;
  walk_e phase;
  logic [7:0] tri_color;

  span_t spans_due[$];
  int errors = 0;
  bit late = 1'b0;

  function automatic int signed col_round(int signed v);
    return v >= 0 ? (v + 8) >>> 4 : -((-v + 8) >>> 4);
  endfunction

  function automatic longint signed row_round(longint signed v);
    return v >= 0 ? (v + 64'sh8000) >>> 16 : -((-v + 64'sh8000) >>> 16);
  endfunction

  function automatic int signed edge_slope(int signed x0, int signed y0,
                                           int signed x1, int signed y1);
    longint signed dx, q;
    dx = longint'(x1) - x0;
    if (dx == 0) return 0;
    q = ((longint'(y1) - y0) * 65536) / dx;
    if (q > 64'sd2147483647) q = 64'sd2147483647;
    if (q < -64'sd2147483648) q = -64'sd2147483648;
    return int'(q);
  endfunction

  function automatic int signed lo_clip(int signed v);
    return v < 0 ? 0 : v;
  endfunction

  function automatic int signed hi_clip(int signed v);
    return v > Screen - 1 ? Screen - 1 : v;
  endfunction

  function automatic longint signed row_of(int signed y, int signed c, int signed s,
                                           int signed m);
    return row_round(longint'(y) * 4096 + (longint'(c) - s) * longint'(m));
  endfunction

  task automatic start_second_half();
    int signed s;
    s = lo_clip(tri_col[1]);
    if (s <= hi_clip(tri_col[2])) begin
      slope_up = edge_slope(tri_v[2], tri_v[3], tri_v[4], tri_v[5]);
      walk_col = s;
      phase = PH_SECOND;
    end else begin
      phase = PH_IDLE;
    end
  endtask

  task automatic predict_span(input request_t r);
    int signed v[6], t;
    int signed c;
    longint signed y1, y2, ty;
    span_t sp;
    bit e;
    if (r.kind == KIND_LOAD) begin
      for (int k = 0; k < 6; k++) v[k] = r.v[k];
      if (v[2] < v[0]) begin
        t = v[0]; v[0] = v[2]; v[2] = t; t = v[1]; v[1] = v[3]; v[3] = t;
      end
      if (v[4] < v[2]) begin
        t = v[2]; v[2] = v[4]; v[4] = t; t = v[3]; v[3] = v[5]; v[5] = t;
      end
      if (v[2] < v[0]) begin
        t = v[0]; v[0] = v[2]; v[2] = t; t = v[1]; v[1] = v[3]; v[3] = t;
      end
      tri_v = v;
      tri_col[0] = col_round(v[0]);
      tri_col[1] = col_round(v[2]);
      tri_col[2] = col_round(v[4]);
      tri_color = r.color;
      slope_long = edge_slope(v[0], v[1], v[4], v[5]);
      if (lo_clip(tri_col[0]) <= hi_clip(tri_col[1])) begin
        slope_up = edge_slope(v[0], v[1], v[2], v[3]);
        walk_col = lo_clip(tri_col[0]);
        phase = PH_FIRST;
      end else begin
        start_second_half();
      end
      return;
    end
    if (phase == PH_IDLE) begin
      sp = '{column: '0, row_top: '0, row_bottom: '0, color: tri_color, empty: 1'b1,
             last: 1'b1};
    end else begin
      c = walk_col;
      if (phase == PH_FIRST) y1 = row_of(tri_v[1], c, tri_col[0], slope_up);
      else y1 = row_of(tri_v[3], c, tri_col[1], slope_up);
      y2 = row_of(tri_v[1], c, tri_col[0], slope_long);
      if (y1 > y2) begin
        ty = y1; y1 = y2; y2 = ty;
      end
      e = (y2 < 0) || (y1 >= Screen);
      if (e) begin
        y1 = 0; y2 = 0;
      end else begin
        if (y1 < 0) y1 = 0;
        if (y2 > Screen - 1) y2 = Screen - 1;
      end
      if (phase == PH_FIRST) begin
        if (c + 1 <= hi_clip(tri_col[1])) walk_col = c + 1;
        else start_second_half();
      end else begin
        if (c + 1 <= hi_clip(tri_col[2])) walk_col = c + 1;
        else phase = PH_IDLE;
      end
      sp.column = c[9:0];
      sp.row_top = y1[9:0];
      sp.row_bottom = y2[9:0];
      sp.color = tri_color;
      sp.empty = e;
      sp.last = (phase == PH_IDLE);
    end
    if (r.has_known && sp !== r.known) begin
      $display("%0t table row predicted %h, typed %h", $time, sp, r.known);
      errors++;
    end
    spans_due.insert(spans_due.size(), sp);
  endtask

  // receive side
  int out_stall = 0;
  int idle_cycles = 0;
  span_t got, want;
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (out_valid_o && out_ready_i) begin
        got = '{column_o, row_top_o, row_bottom_o, span_color_o, span_empty_o, span_last_o};
        if (spans_due.size() == 0) begin
          $display("%0t unexpected span %h", $time, got);
          errors++;
        end else begin
          want = spans_due.pop_front();
          if (got.column !== want.column)
            $display("%0t column: expected %0d, actual %0d", $time, want.column, got.column);
          if (got.row_top !== want.row_top)
            $display("%0t row_top: expected %0d, actual %0d", $time, want.row_top,
                     got.row_top);
          if (got.row_bottom !== want.row_bottom)
            $display("%0t row_bottom: expected %0d, actual %0d", $time, want.row_bottom,
                     got.row_bottom);
          if (got.color !== want.color)
            $display("%0t span_color: expected %0d, actual %0d", $time, want.color, got.color);
          if (got.empty !== want.empty)
            $display("%0t span_empty: expected %0b, actual %0b", $time, want.empty, got.empty);
          if (got.last !== want.last)
            $display("%0t span_last: expected %0b, actual %0b", $time, want.last, got.last);
          if (got !== want) errors++;
        end
      end
      if (out_stall > 0) begin
        out_stall <= out_stall - 1;
        out_ready_i <= 1'b0;
      end else if (!late && $urandom_range(0, 9) == 0) begin
        out_stall <= $urandom_range(1, 12);
        out_ready_i <= 1'b0;
      end else begin
        out_ready_i <= 1'b1;
      end
      // watchdog
      if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) idle_cycles = 0;
      else idle_cycles++;
      if (idle_cycles >= StallLimit) begin
        $display("tb_top: done, errors");
        $finish;
      end
    end
  end

  task automatic send(input request_t r);
    in_valid_i <= 1'b1;
    kind_i <= r.kind;
    vertex_a_x_i <= r.v[0]; vertex_a_y_i <= r.v[1];
    vertex_b_x_i <= r.v[2]; vertex_b_y_i <= r.v[3];
    vertex_c_x_i <= r.v[4]; vertex_c_y_i <= r.v[5];
    fill_color_i <= r.color;
    do @(posedge clk_i); while (!in_ready_o);
    predict_span(r);
    if (!late && $urandom_range(0, 7) == 0) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 12)) @(posedge clk_i);
    end
  endtask

  function automatic request_t make_load(int signed ax, int signed ay, int signed bx,
                                         int signed by, int signed cx, int signed cy,
                                         int color);
    request_t r;
    r.kind = KIND_LOAD;
    r.v[0] = 16'(ax); r.v[1] = 16'(ay); r.v[2] = 16'(bx);
    r.v[3] = 16'(by); r.v[4] = 16'(cx); r.v[5] = 16'(cy);
    r.color = 8'(color);
    r.has_known = 1'b0;
    r.known = '0;
    return r;
  endfunction

  function automatic request_t make_step(bit known_ok, span_t k);
    request_t r;
    r.kind = KIND_STEP;
    for (int i = 0; i < 6; i++) r.v[i] = 16'($urandom);
    r.color = 8'($urandom);
    r.has_known = known_ok;
    r.known = k;
    return r;
  endfunction

  // Q12.4 coordinate: mostly near the screen, sometimes anywhere
  function automatic int signed rand_coord(int mode);
    if (mode == 0) return $signed(16'($urandom));
    if (mode == 1) return $urandom_range(0, 40 * 16) - 160;
    return $urandom_range(0, 900 * 16) - 800;
  endfunction

  request_t plan[$];
  request_t r;
  int mode, steps;

  initial begin
    // step after reset: idle span, color 0
    plan.insert(plan.size(), make_step(1'b1, '{10'd0, 10'd0, 10'd0, 8'd0, 1'b1, 1'b1}));
    // tiny triangle, ties in x keep order, columns 0..1
    plan.insert(plan.size(), make_load(0, 0, 16, 32, 0, 48, 8'hff));
    repeat (4) plan.insert(plan.size(), make_step(1'b0, '0));
    // after the walk ends: idle span with held color
    plan.insert(plan.size(), make_step(1'b1, '{10'd0, 10'd0, 10'd0, 8'hff, 1'b1, 1'b1}));
    // rounding of halves
    plan.insert(plan.size(), make_load(-8, 8, 8, -8, 24, 12792, 8'h00));
    repeat (4) plan.insert(plan.size(), make_step(1'b0, '0));
    // extremes: huge spans, load while walking, then fully off-screen
    plan.insert(plan.size(), make_load(-32768, -32768, 32767, 32767, 0, 32767, 8'h5a));
    repeat (3) plan.insert(plan.size(), make_step(1'b0, '0));
    plan.insert(plan.size(), make_load(32767, -32768, 32767, 32767, 32767, 0, 8'ha5));
    plan.insert(plan.size(), make_step(1'b1, '{10'd0, 10'd0, 10'd0, 8'ha5, 1'b1, 1'b1}));
    plan.insert(plan.size(), make_load(12700, -100, 12790, 20000, 12780, -32768, 8'h33));
    repeat (4) plan.insert(plan.size(), make_step(1'b0, '0));

    phase = PH_IDLE;
    tri_v = '{default: 0};
    tri_col = '{default: 0};
    slope_up = 0; slope_long = 0; walk_col = 0; tri_color = '0;
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (plan[i]) send(plan[i]);

    for (int n = 0; n < 1100; ) begin
      if (n > 950) late = 1'b1;
      mode = $urandom_range(0, 9) == 0 ? 0 : ($urandom_range(0, 3) == 0 ? 2 : 1);
      if (mode == 1) r = make_load($urandom_range(0, 1000) - 100, rand_coord(2),
                                   $urandom_range(0, 1000) - 100, rand_coord(2),
                                   $urandom_range(0, 1000) - 100, rand_coord(2),
                                   $urandom);
      else r = make_load(rand_coord(mode), rand_coord(mode), rand_coord(mode),
                         rand_coord(mode), rand_coord(mode), rand_coord(mode), $urandom);
      send(r);
      n++;
      // walk most of the triangle, sometimes past its end or cut short
      steps = $urandom_range(0, 4) == 0 ? $urandom_range(0, 6) : 70;
      for (int s = 0; s < steps && n < 1100; s++) begin
        send(make_step(1'b0, '0));
        n++;
        if (phase == PH_IDLE && $urandom_range(0, 1)) break;
      end
    end
    in_valid_i <= 1'b0;

    while (spans_due.size() != 0) @(posedge clk_i);
    repeat (200) @(posedge clk_i);
    if (errors == 0) $display("tb_top: done, clean");
    else $display("tb_top: done, errors");
    $finish;
  end

endmodule
